[rtl/lcdpfg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdpfg_pkg
// Types, codes and helpers shared by the LCD pixel frame generator.
// ----------------------------------------------------------------------------
package lcdpfg_pkg;

    localparam int COLOR_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int PAL_W     = 4 * COLOR_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PAL_W;
    localparam int IN_DATA_W = 56;
    localparam int CNT_W     = 4;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        OP_WINDOW   = 3'd0,
        OP_SOLID    = 3'd1,
        OP_BITMAP   = 3'd2,
        OP_GLYPH    = 3'd3,
        OP_RAW_CMD  = 3'd4,
        OP_RAW_DATA = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND    = 2'd0,
        REG_FG      = 2'd1,
        REG_BG      = 2'd2,
        REG_PALETTE = 2'd3
    } t_reg;

    localparam logic [7:0] CMD_COL_0 = 8'h2A;
    localparam logic [7:0] CMD_PAG_0 = 8'h2B;
    localparam logic [7:0] CMD_WR_0  = 8'h2C;
    localparam logic [7:0] CMD_COL_1 = 8'h15;
    localparam logic [7:0] CMD_PAG_1 = 8'h75;
    localparam logic [7:0] CMD_WR_1  = 8'h5C;

    localparam logic [CNT_W-1:0] LAST_WINDOW = 4'd6;
    localparam logic [CNT_W-1:0] LAST_SOLID  = 4'd2;
    localparam logic [CNT_W-1:0] LAST_BITMAP = 4'd5;
    localparam logic [CNT_W-1:0] LAST_GLYPH  = 4'd11;
    localparam logic [CNT_W-1:0] LAST_RAW    = 4'd0;

    typedef struct packed {
        logic               kind;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [PAL_W-1:0]   palette;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [7:0]       x1;
        logic [7:0]       xw;
        logic [7:0]       y1;
        logic [7:0]       yh;
        logic [COLOR_W-1:0] fill;
        logic [7:0]       payload;
        logic [CNT_W-1:0] last_idx;
    } t_desc;

    function automatic logic [COLOR_W-1:0] pal_entry(input logic [PAL_W-1:0] pal,
                                                     input logic [1:0] sel);
        logic [COLOR_W-1:0] c;
        case (sel)
            2'd0:    c = pal[0*COLOR_W +: COLOR_W];
            2'd1:    c = pal[1*COLOR_W +: COLOR_W];
            2'd2:    c = pal[2*COLOR_W +: COLOR_W];
            default: c = pal[3*COLOR_W +: COLOR_W];
        endcase
        return c;
    endfunction

endpackage

[rtl/lcd_pixel_frame_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pixel_frame_generator_top
// Drawing requests in, 9-bit LCD serial frames (flag plus byte) out.
//
//  channel   direction  payload
//  s_axis    in         tuser: operation[2:0]; tdata: x, y, w, h, fill, payload
//  m_axis    out        tuser: is_data; tdata: frame_byte; tlast: last
//  cfg       in         i_cfg_we, i_cfg_addr, i_cfg_data (write only)
//
// One output beat per cycle while the receiver is ready; a request gives
// 1 to 12 frames, which the back sequencer steps into the output register.
// Requests with codes 6 and 7 take one input beat and give nothing.
// Synchronous active-low reset clears handshake state and the config registers.
// Either side may stall; a two-entry queue parts front and back.
// ----------------------------------------------------------------------------
module lcd_pixel_frame_generator_top import lcdpfg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: win_x[7:0], win_y[15:8], win_w[23:16], win_h[31:24],
    //        fill_color[43:32], payload[51:44], zero pad [55:52]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: frame_byte[7:0]
    output logic [7:0]           m_axis_tdata,
    // tuser: is_data[0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  f_valid, q_full, q_valid, q_pop;
    t_desc f_desc, q_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_addr))
                REG_KIND:    r_cfg.kind    <= i_cfg_data[0];
                REG_FG:      r_cfg.fg      <= i_cfg_data[COLOR_W-1:0];
                REG_BG:      r_cfg.bg      <= i_cfg_data[COLOR_W-1:0];
                REG_PALETTE: r_cfg.palette <= i_cfg_data[PAL_W-1:0];
                default: ;
            endcase
        end
    end

    lcdpfg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_win_x      (s_axis_tdata[7:0]),
        .i_win_y      (s_axis_tdata[15:8]),
        .i_win_w      (s_axis_tdata[23:16]),
        .i_win_h      (s_axis_tdata[31:24]),
        .i_fill_color (s_axis_tdata[43:32]),
        .i_payload    (s_axis_tdata[51:44]),
        .o_valid      (f_valid),
        .o_desc       (f_desc),
        .i_ready      (!q_full)
    );

    lcdpfg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_desc  (f_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    lcdpfg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_desc   (q_desc),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

[rtl/lcdpfg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdpfg_front
// Accepts requests, drops unused codes, precomputes window sums and last frame index.
// ----------------------------------------------------------------------------
module lcdpfg_front import lcdpfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_win_x,
    input  logic [7:0]         i_win_y,
    input  logic [7:0]         i_win_w,
    input  logic [7:0]         i_win_h,
    input  logic [COLOR_W-1:0] i_fill_color,
    input  logic [7:0]         i_payload,
    output logic               o_valid,
    output t_desc              o_desc,
    input  logic               i_ready
);

    logic  r_valid, n_valid;
    t_desc r_desc, n_desc;
    logic  op_ok;
    logic  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_desc  = r_desc;

    always_comb begin
        n_desc         = r_desc;
        op_ok          = 1'b1;
        n_desc.op      = t_op'(i_op);
        n_desc.x1      = i_win_x + 8'd1;
        n_desc.xw      = i_win_x + i_win_w;
        n_desc.y1      = i_win_y + 8'd1;
        n_desc.yh      = i_win_y + i_win_h;
        n_desc.fill    = i_fill_color;
        n_desc.payload = i_payload;
        unique case (i_op)
            OP_WINDOW:   n_desc.last_idx = LAST_WINDOW;
            OP_SOLID:    n_desc.last_idx = LAST_SOLID;
            OP_BITMAP:   n_desc.last_idx = LAST_BITMAP;
            OP_GLYPH:    n_desc.last_idx = LAST_GLYPH;
            OP_RAW_CMD,
            OP_RAW_DATA: n_desc.last_idx = LAST_RAW;
            default: begin
                n_desc.last_idx = LAST_RAW;
                op_ok           = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (accept && op_ok) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

[rtl/lcdpfg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdpfg_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module lcdpfg_fifo import lcdpfg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QPTR_W:0]     r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

[rtl/lcdpfg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdpfg_back
// Steps through the frames of one request, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdpfg_back import lcdpfg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_desc       i_desc,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [7:0]  o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);

    logic             r_busy, n_busy;
    t_desc            r_desc;
    logic [CNT_W-1:0] r_idx;
    logic [1:0]       r_phase;
    logic [1:0]       r_pair;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_obyte;
    logic             r_odata;
    logic             r_olast;

    logic               adv, is_last;
    logic [7:0]         f_byte;
    logic               f_data;
    logic [COLOR_W-1:0] col_a, col_b, inv_a, inv_b;
    logic [7:0]         pix_byte;
    logic [7:0]         cmd_col, cmd_pag, cmd_wr;

    assign adv     = r_busy && (!r_ovalid || i_tready);
    assign is_last = (r_idx == r_desc.last_idx);
    assign o_pop   = i_valid && (!r_busy || (adv && is_last));

    assign cmd_col = i_cfg.kind ? CMD_COL_1 : CMD_COL_0;
    assign cmd_pag = i_cfg.kind ? CMD_PAG_1 : CMD_PAG_0;
    assign cmd_wr  = i_cfg.kind ? CMD_WR_1  : CMD_WR_0;

    always_comb begin
        unique case (r_desc.op)
            OP_BITMAP: begin
                col_a = pal_entry(i_cfg.palette, r_desc.payload[{r_pair[0], 2'b00} +: 2]);
                col_b = pal_entry(i_cfg.palette, r_desc.payload[{r_pair[0], 2'b10} +: 2]);
            end
            OP_GLYPH: begin
                col_a = r_desc.payload[{r_pair, 1'b0}] ? i_cfg.fg : i_cfg.bg;
                col_b = r_desc.payload[{r_pair, 1'b1}] ? i_cfg.fg : i_cfg.bg;
            end
            default: begin
                col_a = r_desc.fill;
                col_b = r_desc.fill;
            end
        endcase
        inv_a = ~col_a;
        inv_b = ~col_b;
        unique case (r_phase)
            2'd0:    pix_byte = inv_a[11:4];
            2'd1:    pix_byte = {inv_a[3:0], inv_b[11:8]};
            default: pix_byte = inv_b[7:0];
        endcase
    end

    always_comb begin
        f_data = 1'b1;
        f_byte = pix_byte;
        unique case (r_desc.op)
            OP_WINDOW: begin
                unique case (r_idx)
                    4'd0: begin f_data = 1'b0; f_byte = cmd_col; end
                    4'd1: f_byte = r_desc.x1;
                    4'd2: f_byte = r_desc.xw;
                    4'd3: begin f_data = 1'b0; f_byte = cmd_pag; end
                    4'd4: f_byte = r_desc.y1;
                    4'd5: f_byte = r_desc.yh;
                    default: begin f_data = 1'b0; f_byte = cmd_wr; end
                endcase
            end
            OP_RAW_CMD: begin
                f_data = 1'b0;
                f_byte = r_desc.payload;
            end
            OP_RAW_DATA: f_byte = r_desc.payload;
            default: f_byte = pix_byte;
        endcase
    end

    always_comb begin
        if (o_pop) begin
            n_busy = 1'b1;
        end else if (adv && is_last) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
        if (adv) begin
            n_ovalid = 1'b1;
        end else if (i_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_phase  <= '0;
            r_pair   <= '0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            if (o_pop) begin
                r_idx   <= '0;
                r_phase <= '0;
                r_pair  <= '0;
            end else if (adv) begin
                r_idx <= r_idx + 1'b1;
                if (r_phase == 2'd2) begin
                    r_phase <= '0;
                    r_pair  <= r_pair + 1'b1;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (adv) begin
            r_obyte <= f_byte;
            r_odata <= f_data;
            r_olast <= is_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obyte;
    assign o_tuser  = r_odata;
    assign o_tlast  = r_olast;

endmodule

[dv/lcd_pixel_frame_generator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pixel_frame_generator_top_tb
// Self-checking bench for the LCD pixel frame generator. Drawing requests are
// streamed in under several register settings; both stream sides stall at
// random save in the last run. Each accepted request's frames are worked out
// here and compared beat by beat with the output stream, in order.
// ----------------------------------------------------------------------------
module lcd_pixel_frame_generator_top_tb;
    import lcdpfg_pkg::*;

    typedef struct {
        logic       is_data;
        logic [7:0] fbyte;
        logic       last;
    } t_frame;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // shadow of the block's registers
    logic               kind_sh;
    logic [COLOR_W-1:0] fg_sh;
    logic [COLOR_W-1:0] bg_sh;
    logic [PAL_W-1:0]   pal_sh;

    t_frame frames_due[$];
    int     err_cnt   = 0;
    bit     calm      = 1'b0;
    int     hold_left = 0;

    lcd_pixel_frame_generator_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // ---- frame prediction ----
    function automatic void pack_pair(ref t_frame fr[$], input logic [11:0] a,
                                      input logic [11:0] b);
        logic [11:0] ai;
        logic [11:0] bi;
        ai = ~a;
        bi = ~b;
        fr.push_back('{1'b1, ai[11:4], 1'b0});
        fr.push_back('{1'b1, {ai[3:0], bi[11:8]}, 1'b0});
        fr.push_back('{1'b1, bi[7:0], 1'b0});
    endfunction

    function automatic void predict_frames(input logic [2:0] op, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] w,
                                           input logic [7:0] h, input logic [11:0] fill,
                                           input logic [7:0] pl);
        t_frame      fr[$];
        logic [7:0]  bits;
        logic [11:0] a;
        logic [11:0] b;
        bits = pl;
        case (op)
            OP_WINDOW: begin
                fr.push_back('{1'b0, kind_sh ? CMD_COL_1 : CMD_COL_0, 1'b0});
                fr.push_back('{1'b1, 8'(x + 8'd1), 1'b0});
                fr.push_back('{1'b1, 8'(x + w), 1'b0});
                fr.push_back('{1'b0, kind_sh ? CMD_PAG_1 : CMD_PAG_0, 1'b0});
                fr.push_back('{1'b1, 8'(y + 8'd1), 1'b0});
                fr.push_back('{1'b1, 8'(y + h), 1'b0});
                fr.push_back('{1'b0, kind_sh ? CMD_WR_1 : CMD_WR_0, 1'b0});
            end
            OP_SOLID: pack_pair(fr, fill, fill);
            OP_BITMAP: begin
                for (int k = 0; k < 2; k++) begin
                    a = pal_sh[bits[1:0]*COLOR_W +: COLOR_W];
                    b = pal_sh[bits[3:2]*COLOR_W +: COLOR_W];
                    pack_pair(fr, a, b);
                    bits = bits >> 4;
                end
            end
            OP_GLYPH: begin
                for (int k = 0; k < 4; k++) begin
                    a = bits[0] ? fg_sh : bg_sh;
                    b = bits[1] ? fg_sh : bg_sh;
                    pack_pair(fr, a, b);
                    bits = bits >> 2;
                end
            end
            OP_RAW_CMD:  fr.push_back('{1'b0, pl, 1'b0});
            OP_RAW_DATA: fr.push_back('{1'b1, pl, 1'b0});
            default: ;
        endcase
        if (fr.size() > 0)
            fr[$].last = 1'b1;
        foreach (fr[i])
            frames_due.push_back(fr[i]);
    endfunction

    // ---- output check ----
    always @(posedge i_clk) begin
        t_frame exp_fr;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frames_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected beat data=%0d byte=%h last=%0d", $time,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                exp_fr = frames_due.pop_front();
                if (m_axis_tuser !== exp_fr.is_data) begin
                    err_cnt++;
                    $display("%0t: is_data exp %0d got %0d", $time, exp_fr.is_data,
                             m_axis_tuser);
                end
                if (m_axis_tdata !== exp_fr.fbyte) begin
                    err_cnt++;
                    $display("%0t: frame_byte exp %h got %h", $time, exp_fr.fbyte,
                             m_axis_tdata);
                end
                if (m_axis_tlast !== exp_fr.last) begin
                    err_cnt++;
                    $display("%0t: last exp %0d got %0d", $time, exp_fr.last,
                             m_axis_tlast);
                end
            end
        end
    end

    // ---- receiver: random stalls, plus long hold-off on request ----
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic send_req(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] w, input logic [7:0] h,
                            input logic [11:0] fill, input logic [7:0] pl,
                            input bit gaps = 1'b1);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'h0, pl, fill, h, w, y, x};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_frames(op, x, y, w, h, fill, pl);
        if (!calm && gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_simple(input logic [2:0] op, input logic [11:0] fill,
                               input logic [7:0] pl);
        send_req(op, 8'h00, 8'h00, 8'h00, 8'h00, fill, pl);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        // ignored codes give no frame, so allow the pipe to empty
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_KIND:    kind_sh = val[0];
            REG_FG:      fg_sh   = val[COLOR_W-1:0];
            REG_BG:      bg_sh   = val[COLOR_W-1:0];
            REG_PALETTE: pal_sh  = val[PAL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic kind, input logic [11:0] fg, input logic [11:0] bg,
                            input logic [PAL_W-1:0] pal);
        write_reg(REG_KIND, CFG_DAT_W'(kind));
        write_reg(REG_FG, CFG_DAT_W'(fg));
        write_reg(REG_BG, CFG_DAT_W'(bg));
        write_reg(REG_PALETTE, pal);
        i_cfg_we <= 1'b0;
    endtask

    // ---- tests ----
    // reset register values, field extremes, all operations, wrapping sums,
    // unused codes
    task automatic test_directed();
        send_req(OP_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00, 12'h000, 8'h00);
        send_req(OP_WINDOW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 8'hFF);
        send_req(OP_WINDOW, 8'h10, 8'h20, 8'h7F, 8'hE0, 12'h123, 8'h5A);
        send_simple(OP_SOLID, 12'h000, 8'h00);
        send_simple(OP_SOLID, 12'hFFF, 8'hFF);
        send_simple(OP_BITMAP, 12'h000, 8'hE4);
        send_simple(OP_GLYPH, 12'h000, 8'hA5);
        send_simple(OP_RAW_CMD, 12'h000, 8'h00);
        send_simple(OP_RAW_CMD, 12'hFFF, 8'hFF);
        send_simple(OP_RAW_DATA, 12'h000, 8'h00);
        send_simple(OP_RAW_DATA, 12'hFFF, 8'hFF);
        send_req(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 8'hFF);
        send_req(3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 12'h000, 8'h00);
        send_simple(OP_RAW_DATA, 12'h000, 8'h3C);
        drain();
    endtask

    task automatic test_kind1_colours();
        set_regs(1'b1, 12'hFFF, 12'h000, {12'hFFF, 12'h000, 12'hA5A, 12'h5C3});
        send_req(OP_WINDOW, 8'hFE, 8'h01, 8'h02, 8'hFF, 12'h000, 8'h00);
        send_simple(OP_BITMAP, 12'h000, 8'h00);
        send_simple(OP_BITMAP, 12'h000, 8'hFF);
        send_simple(OP_BITMAP, 12'h000, 8'h1B);
        send_simple(OP_GLYPH, 12'h000, 8'h00);
        send_simple(OP_GLYPH, 12'h000, 8'hFF);
        send_simple(OP_GLYPH, 12'h000, 8'h69);
        drain();
    endtask

    task automatic test_random(input int n_items);
        logic [2:0] op;
        int         done;
        done = 0;
        while (done < n_items) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            send_req(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     12'($urandom), 8'($urandom));
            if (op <= OP_RAW_DATA)
                done++;
        end
        drain();
    endtask

    // output held off while glyph bursts keep coming; input must back up
    task automatic test_backpressure();
        hold_left = 300;
        repeat (12)
            send_req(OP_GLYPH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     12'($urandom), 8'($urandom), 1'b0);
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        kind_sh = 1'b0;
        fg_sh   = '0;
        bg_sh   = '0;
        pal_sh  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        test_directed();
        test_kind1_colours();
        test_backpressure();
        set_regs(1'b0, 12'h000, 12'hFFF, {PAL_W{1'b1}});
        test_random(45);
        set_regs(1'b1, 12'($urandom), 12'($urandom), PAL_W'({$urandom, $urandom}));
        test_random(45);
        set_regs(1'b0, 12'($urandom), 12'($urandom), '0);
        test_random(40);
        calm = 1'b1;
        set_regs(1'($urandom), 12'($urandom), 12'($urandom), PAL_W'({$urandom, $urandom}));
        test_random(40);

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/lcdpfg_pkg.sv
rtl/lcdpfg_front.sv
rtl/lcdpfg_fifo.sv
rtl/lcdpfg_back.sv
rtl/lcd_pixel_frame_generator_top.sv
dv/lcd_pixel_frame_generator_top_tb.sv
